// ===== design/rpnsc_pkg.sv =====
// Shared constants for the RPN stack calculator: command and status codes
// and field widths. No dependencies.
`default_nettype none

package rpnsc_pkg;

  localparam int unsigned MODE_W   = 4;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 5;

  // Command codes carried in the input tuser.
  localparam logic [MODE_W-1:0] MODE_PUSH  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SWAP  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_DUP   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_PEEK  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_DUMP  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_ADD   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_SUB   = 4'd8;
  localparam logic [MODE_W-1:0] MODE_MUL   = 4'd9;
  localparam logic [MODE_W-1:0] MODE_DIV   = 4'd10;

  // Result status codes carried in the output tuser.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIV0 = 2'd3;

  // Shift-add multiply and restoring divide run one bit per cycle.
  localparam int unsigned  ITER_W    = 5;
  localparam logic [ITER_W-1:0] ITER_LAST = 5'd31;

endpackage : rpnsc_pkg

`default_nettype wire

// ===== design/rpn_stack_calculator.sv =====
// RPN stack calculator: command sequencer, stack memory and one shared
// 33-bit add/subtract unit for add, sub, shift-add multiply and divide.
// Depends on rpnsc_pkg.
// Usage:
//   Commands arrive on the s_axis channel: tuser carries the command code,
//   tdata the signed value to push. Results leave on the m_axis channel:
//   tdata carries the value and the fill level after the command, tuser the
//   status, tlast marks the final result of the command. Every command gives
//   one result; dump gives one per entry, top first.
//   s_axis_tready is high only while the sequencer is idle, so one command is
//   worked on at a time. A finished result sits in the output register and
//   the next command is taken while it waits.
//   Divide runs a sign fix, 32 restoring steps and a sign restore through
//   the shared adder.
//   When the receiver stalls, the result holds in the output register and the
//   sequencer waits before placing the next one.
//   Reset empties the stack and drops any pending result; the stack words
//   themselves are not cleared and are never read before they are written.
`default_nettype none

module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] value
  input  wire logic [3:0]  s_axis_tuser,  // [3:0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [31:0] data, [36:32] fill_level, rest zero
  output logic [1:0]       m_axis_tuser,  // [1:0] status
  output logic             m_axis_tlast   // last
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned W  = rpnsc_pkg::WORD_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD1  = 4'd1;
  localparam logic [3:0] S_RD2  = 4'd2;
  localparam logic [3:0] S_SWAP = 4'd3;
  localparam logic [3:0] S_DABS = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_DFIX = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_WB   = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;
  localparam logic [3:0] S_DRD  = 4'd10;
  localparam logic [3:0] S_DOUT = 4'd11;

  logic [3:0]                      state;
  logic [CW-1:0]                   cnt;
  logic [AW-1:0]                   ptr;
  logic [rpnsc_pkg::MODE_W-1:0]    mode_q;
  logic [W-1:0]                    opa;
  logic [W-1:0]                    opb;
  logic [W-1:0]                    acc;
  logic                            neg_q;
  logic [rpnsc_pkg::ITER_W-1:0]    iter;
  logic [W-1:0]                    res_data;
  logic [rpnsc_pkg::STATUS_W-1:0]  res_status;

  logic [W-1:0] mem [STACK_DEPTH];
  logic [W-1:0] rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [W-1:0]  mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [AW-1:0] addr_top;
  logic [AW-1:0] addr_sec;
  logic [AW-1:0] addr_new;
  logic          full;
  logic          few1;
  logic          few2;
  logic          accept;
  logic          out_free;
  logic          emit_now;

  logic [W-1:0]  alu_a;
  logic [W-1:0]  alu_b;
  logic          alu_sub;
  logic [W:0]    alu_res;
  logic [W-1:0]  div_rs;

  assign cnt_m1   = cnt - CW'(1);
  assign cnt_m2   = cnt - CW'(2);
  assign addr_top = cnt_m1[AW-1:0];
  assign addr_sec = cnt_m2[AW-1:0];
  assign addr_new = cnt[AW-1:0];
  assign full     = (cnt == CW'(STACK_DEPTH));
  assign few1     = (cnt == '0);
  assign few2     = (cnt < CW'(2));

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit_now      = ((state == S_EMIT) || (state == S_DOUT)) && out_free;
  assign div_rs        = {acc[W-2:0], opa[W-1]};

  // Shared adder: carry out set means a >= b on subtract.
  always_comb begin
    alu_a   = acc;
    alu_b   = opa;
    alu_sub = 1'b0;
    case (state)
      S_RD2: begin
        if (mode_q == rpnsc_pkg::MODE_DIV) begin
          alu_a   = '0;
          alu_b   = opb;
          alu_sub = 1'b1;
        end else begin
          alu_a   = rd_data;
          alu_b   = opb;
          alu_sub = (mode_q == rpnsc_pkg::MODE_SUB);
        end
      end
      S_DABS, S_DFIX: begin
        alu_a   = '0;
        alu_b   = opa;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = div_rs;
        alu_b   = opb;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = acc;
        alu_b   = opa;
        alu_sub = 1'b0;
      end
    endcase
    alu_res = {1'b0, alu_a} + {1'b0, alu_b ^ {W{alu_sub}}} + (W+1)'(alu_sub);
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_new;
    mem_wdata = s_axis_tdata;
    case (state)
      S_IDLE: begin
        mem_we = accept && (s_axis_tuser == rpnsc_pkg::MODE_PUSH) && !full;
      end
      S_RD1: begin
        mem_we    = (mode_q == rpnsc_pkg::MODE_DUP);
        mem_wdata = rd_data;
      end
      S_RD2: begin
        mem_we    = (mode_q == rpnsc_pkg::MODE_SWAP);
        mem_waddr = addr_top;
        mem_wdata = rd_data;
      end
      S_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = addr_sec;
        mem_wdata = opb;
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = addr_sec;
        mem_wdata = acc;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    case (state)
      S_RD1:         mem_raddr = addr_sec;
      S_DRD, S_DOUT: mem_raddr = ptr;
      default:       mem_raddr = addr_top;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && !emit_now) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            mode_q   <= s_axis_tuser;
            res_data <= '0;
            case (s_axis_tuser)
              rpnsc_pkg::MODE_PUSH: begin
                state <= S_EMIT;
                if (full) begin
                  res_status <= rpnsc_pkg::ST_FULL;
                end else begin
                  res_status <= rpnsc_pkg::ST_OK;
                  cnt        <= cnt + CW'(1);
                end
              end
              rpnsc_pkg::MODE_CLEAR: begin
                res_status <= rpnsc_pkg::ST_OK;
                cnt        <= '0;
                state      <= S_EMIT;
              end
              rpnsc_pkg::MODE_POP, rpnsc_pkg::MODE_PEEK: begin
                if (few1) begin
                  res_status <= rpnsc_pkg::ST_FEW;
                  state      <= S_EMIT;
                end else begin
                  res_status <= rpnsc_pkg::ST_OK;
                  state      <= S_RD1;
                end
              end
              rpnsc_pkg::MODE_DUP: begin
                if (few1) begin
                  res_status <= rpnsc_pkg::ST_FEW;
                  state      <= S_EMIT;
                end else if (full) begin
                  res_status <= rpnsc_pkg::ST_FULL;
                  state      <= S_EMIT;
                end else begin
                  res_status <= rpnsc_pkg::ST_OK;
                  state      <= S_RD1;
                end
              end
              rpnsc_pkg::MODE_DUMP: begin
                if (few1) begin
                  res_status <= rpnsc_pkg::ST_FEW;
                  state      <= S_EMIT;
                end else begin
                  res_status <= rpnsc_pkg::ST_OK;
                  ptr        <= addr_top;
                  state      <= S_DRD;
                end
              end
              rpnsc_pkg::MODE_SWAP, rpnsc_pkg::MODE_ADD, rpnsc_pkg::MODE_SUB,
              rpnsc_pkg::MODE_MUL, rpnsc_pkg::MODE_DIV: begin
                if (few2) begin
                  res_status <= rpnsc_pkg::ST_FEW;
                  state      <= S_EMIT;
                end else begin
                  res_status <= rpnsc_pkg::ST_OK;
                  state      <= S_RD1;
                end
              end
              default: begin
                res_status <= rpnsc_pkg::ST_OK;
                state      <= S_EMIT;
              end
            endcase
          end
        end

        S_RD1: begin
          // rd_data holds the top entry
          opb <= rd_data;
          case (mode_q)
            rpnsc_pkg::MODE_POP: begin
              res_data <= rd_data;
              cnt      <= cnt_m1;
              state    <= S_EMIT;
            end
            rpnsc_pkg::MODE_PEEK: begin
              res_data <= rd_data;
              state    <= S_EMIT;
            end
            rpnsc_pkg::MODE_DUP: begin
              cnt   <= cnt + CW'(1);
              state <= S_EMIT;
            end
            default: begin
              state <= S_RD2;
            end
          endcase
        end

        S_RD2: begin
          // rd_data holds the second entry
          opa <= rd_data;
          case (mode_q)
            rpnsc_pkg::MODE_SWAP: begin
              state <= S_SWAP;
            end
            rpnsc_pkg::MODE_MUL: begin
              acc   <= '0;
              iter  <= '0;
              state <= S_MUL;
            end
            rpnsc_pkg::MODE_DIV: begin
              if (opb == '0) begin
                res_status <= rpnsc_pkg::ST_DIV0;
                state      <= S_EMIT;
              end else begin
                neg_q <= rd_data[W-1] ^ opb[W-1];
                if (opb[W-1]) begin
                  opb <= alu_res[W-1:0];
                end
                state <= S_DABS;
              end
            end
            default: begin
              acc   <= alu_res[W-1:0];
              state <= S_WB;
            end
          endcase
        end

        S_SWAP: begin
          state <= S_EMIT;
        end

        S_DABS: begin
          if (opa[W-1]) begin
            opa <= alu_res[W-1:0];
          end
          acc   <= '0;
          iter  <= '0;
          state <= S_DIV;
        end

        S_DIV: begin
          // restoring step: remainder in acc, dividend shifts out of opa
          // while quotient bits shift in
          if (alu_res[W]) begin
            acc <= alu_res[W-1:0];
          end else begin
            acc <= div_rs;
          end
          opa  <= {opa[W-2:0], alu_res[W]};
          iter <= iter + rpnsc_pkg::ITER_W'(1);
          if (iter == rpnsc_pkg::ITER_LAST) begin
            state <= S_DFIX;
          end
        end

        S_DFIX: begin
          acc   <= neg_q ? alu_res[W-1:0] : opa;
          state <= S_WB;
        end

        S_MUL: begin
          if (opb[0]) begin
            acc <= alu_res[W-1:0];
          end
          opa  <= {opa[W-2:0], 1'b0};
          opb  <= {1'b0, opb[W-1:1]};
          iter <= iter + rpnsc_pkg::ITER_W'(1);
          if (iter == rpnsc_pkg::ITER_LAST) begin
            state <= S_WB;
          end
        end

        S_WB: begin
          res_data <= acc;
          cnt      <= cnt_m1;
          state    <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, rpnsc_pkg::FILL_W'(cnt), res_data};
            m_axis_tuser  <= res_status;
            m_axis_tlast  <= 1'b1;
            state         <= S_IDLE;
          end
        end

        S_DRD: begin
          // wait for the registered read of entry ptr
          state <= S_DOUT;
        end

        S_DOUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, rpnsc_pkg::FILL_W'(cnt), rd_data};
            m_axis_tuser  <= rpnsc_pkg::ST_OK;
            m_axis_tlast  <= (ptr == '0);
            if (ptr == '0) begin
              state <= S_IDLE;
            end else begin
              ptr   <= ptr - AW'(1);
              state <= S_DRD;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while one is in progress");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (AW+1)'(mem_waddr) < (AW+1)'(STACK_DEPTH))
    else $error("stack write beyond depth");

  a_dump_order: assert property (@(posedge clk) disable iff (rst)
    state == S_DOUT && out_free && ptr != '0 |=> state == S_DRD && ptr == $past(ptr) - AW'(1))
    else $error("dump walk lost its place");
`endif

endmodule : rpn_stack_calculator

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for the RPN stack calculator: directed command table,
// then random command sequences; each result is checked against its typed table value or a local model.
// Depends on rpnsc_pkg and rpn_stack_calculator.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned STACK_DEPTH      = 16;
  localparam int unsigned RANDOM_ITEMS     = 140;
  localparam int unsigned CALM_ITEMS       = 30;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES     = 80;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned MAX_REPORTS      = 10;

  // Codes the calculator ignores.
  localparam logic [rpnsc_pkg::MODE_W-1:0] MODE_UNUSED_LO = 4'd11;
  localparam logic [rpnsc_pkg::MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

  localparam logic [rpnsc_pkg::WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [rpnsc_pkg::WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [rpnsc_pkg::WORD_W-1:0] WORD_NEG1 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [rpnsc_pkg::WORD_W-1:0]   data;
    logic [rpnsc_pkg::STATUS_W-1:0] status;
    logic [rpnsc_pkg::FILL_W-1:0]   fill;
    logic                           last;
  } calc_result_t;

  typedef struct packed {
    logic [rpnsc_pkg::MODE_W-1:0]   mode;
    logic [rpnsc_pkg::WORD_W-1:0]   value;
    logic                           typed;
    logic [rpnsc_pkg::WORD_W-1:0]   data;
    logic [rpnsc_pkg::STATUS_W-1:0] status;
    logic [rpnsc_pkg::FILL_W-1:0]   fill;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Model of the calculator and the results it still owes.
  logic [rpnsc_pkg::WORD_W-1:0] calc_stack [STACK_DEPTH];
  int unsigned                  calc_depth = 0;
  calc_result_t                 owed_results [$];

  stim_row_t directed_rows [$];

  bit          idle_on = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned commands_sent = 0;
  int unsigned live_commands = 0;
  int unsigned ignored_commands = 0;
  int unsigned dumps_done = 0;
  int unsigned full_rejects = 0;
  int unsigned quiet_cycles = 0;

  rpn_stack_calculator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [rpnsc_pkg::WORD_W-1:0] quotient_toward_zero(
      logic [rpnsc_pkg::WORD_W-1:0] num, logic [rpnsc_pkg::WORD_W-1:0] den);
    logic [rpnsc_pkg::WORD_W-1:0] mag_n;
    logic [rpnsc_pkg::WORD_W-1:0] mag_d;
    logic [rpnsc_pkg::WORD_W-1:0] q;
    mag_n = num[rpnsc_pkg::WORD_W-1] ? -num : num;
    mag_d = den[rpnsc_pkg::WORD_W-1] ? -den : den;
    q = mag_n / mag_d;
    return (num[rpnsc_pkg::WORD_W-1] ^ den[rpnsc_pkg::WORD_W-1]) ? -q : q;
  endfunction

  function automatic void owe(logic [rpnsc_pkg::WORD_W-1:0] data,
                              logic [rpnsc_pkg::STATUS_W-1:0] status, logic last);
    calc_result_t r;
    r.data   = data;
    r.status = status;
    r.fill   = calc_depth[rpnsc_pkg::FILL_W-1:0];
    r.last   = last;
    owed_results.push_back(r);
  endfunction

  function automatic void add_row(logic [rpnsc_pkg::MODE_W-1:0] mode,
                                  logic [rpnsc_pkg::WORD_W-1:0] value, logic typed,
                                  logic [rpnsc_pkg::WORD_W-1:0] data,
                                  logic [rpnsc_pkg::STATUS_W-1:0] status,
                                  logic [rpnsc_pkg::FILL_W-1:0] fill);
    stim_row_t r;
    r.mode   = mode;
    r.value  = value;
    r.typed  = typed;
    r.data   = data;
    r.status = status;
    r.fill   = fill;
    directed_rows.push_back(r);
  endfunction

  // Apply one command to the model stack and queue the results it causes.
  function automatic void calc_step(logic [rpnsc_pkg::MODE_W-1:0] mode,
                                    logic [rpnsc_pkg::WORD_W-1:0] value);
    int unsigned                  n;
    logic [rpnsc_pkg::WORD_W-1:0] top;
    logic [rpnsc_pkg::WORD_W-1:0] sec;
    logic [rpnsc_pkg::WORD_W-1:0] res;
    n = calc_depth;
    case (mode)
      rpnsc_pkg::MODE_PUSH: begin
        if (n >= STACK_DEPTH) begin
          full_rejects++;
          owe('0, rpnsc_pkg::ST_FULL, 1'b1);
        end else begin
          calc_stack[n] = value;
          calc_depth = n + 1;
          owe('0, rpnsc_pkg::ST_OK, 1'b1);
        end
      end
      rpnsc_pkg::MODE_POP: begin
        if (n == 0) begin
          owe('0, rpnsc_pkg::ST_FEW, 1'b1);
        end else begin
          calc_depth = n - 1;
          owe(calc_stack[n-1], rpnsc_pkg::ST_OK, 1'b1);
        end
      end
      rpnsc_pkg::MODE_CLEAR: begin
        calc_depth = 0;
        owe('0, rpnsc_pkg::ST_OK, 1'b1);
      end
      rpnsc_pkg::MODE_SWAP: begin
        if (n < 2) begin
          owe('0, rpnsc_pkg::ST_FEW, 1'b1);
        end else begin
          top = calc_stack[n-1];
          calc_stack[n-1] = calc_stack[n-2];
          calc_stack[n-2] = top;
          owe('0, rpnsc_pkg::ST_OK, 1'b1);
        end
      end
      rpnsc_pkg::MODE_DUP: begin
        if (n == 0) begin
          owe('0, rpnsc_pkg::ST_FEW, 1'b1);
        end else if (n >= STACK_DEPTH) begin
          full_rejects++;
          owe('0, rpnsc_pkg::ST_FULL, 1'b1);
        end else begin
          calc_stack[n] = calc_stack[n-1];
          calc_depth = n + 1;
          owe('0, rpnsc_pkg::ST_OK, 1'b1);
        end
      end
      rpnsc_pkg::MODE_PEEK: begin
        if (n == 0) owe('0, rpnsc_pkg::ST_FEW, 1'b1);
        else owe(calc_stack[n-1], rpnsc_pkg::ST_OK, 1'b1);
      end
      rpnsc_pkg::MODE_DUMP: begin
        if (n == 0) begin
          owe('0, rpnsc_pkg::ST_FEW, 1'b1);
        end else begin
          dumps_done++;
          for (int i = 0; i < n; i++) owe(calc_stack[n-1-i], rpnsc_pkg::ST_OK, i + 1 == n);
        end
      end
      rpnsc_pkg::MODE_ADD, rpnsc_pkg::MODE_SUB, rpnsc_pkg::MODE_MUL,
      rpnsc_pkg::MODE_DIV: begin
        if (n < 2) begin
          owe('0, rpnsc_pkg::ST_FEW, 1'b1);
        end else begin
          top = calc_stack[n-1];
          sec = calc_stack[n-2];
          if (mode == rpnsc_pkg::MODE_DIV && top == '0) begin
            owe('0, rpnsc_pkg::ST_DIV0, 1'b1);
          end else begin
            case (mode)
              rpnsc_pkg::MODE_ADD: res = sec + top;
              rpnsc_pkg::MODE_SUB: res = sec - top;
              rpnsc_pkg::MODE_MUL: res = sec * top;
              default:             res = quotient_toward_zero(sec, top);
            endcase
            calc_stack[n-2] = res;
            calc_depth = n - 1;
            owe(res, rpnsc_pkg::ST_OK, 1'b1);
          end
        end
      end
      default: owe('0, rpnsc_pkg::ST_OK, 1'b1);
    endcase
  endfunction

  function automatic logic [rpnsc_pkg::WORD_W-1:0] pick_word();
    logic [rpnsc_pkg::WORD_W-1:0] w;
    case ($urandom_range(0, 7))
      0: w = WORD_MIN;
      1: w = WORD_MAX;
      2: w = WORD_NEG1;
      3: w = '0;
      4, 5: begin
        w = $urandom_range(0, 40);
        w = w - 32'd20;
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Offer one command and return at the edge where it is taken.
  task automatic send_command(logic [rpnsc_pkg::MODE_W-1:0] mode,
                              logic [rpnsc_pkg::WORD_W-1:0] value);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= mode;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    commands_sent++;
    if (mode <= rpnsc_pkg::MODE_DIV) live_commands++;
    else ignored_commands++;
    calc_step(mode, value);
  endtask

  task automatic note_mismatch(string field, logic [rpnsc_pkg::WORD_W-1:0] want,
                               logic [rpnsc_pkg::WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, field, want, got);
  endtask

  task automatic check_result();
    calc_result_t want;
    results_seen++;
    if (owed_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] unexpected result: tdata %h tuser %h tlast %b", $time,
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end else begin
      want = owed_results.pop_front();
      if (m_axis_tdata[31:0] !== want.data) note_mismatch("data", want.data, m_axis_tdata[31:0]);
      if (m_axis_tdata[36:32] !== want.fill)
        note_mismatch("fill_level", 32'(want.fill), 32'(m_axis_tdata[36:32]));
      if (m_axis_tdata[39:37] !== 3'b000)
        note_mismatch("tdata pad", '0, 32'(m_axis_tdata[39:37]));
      if (m_axis_tuser !== want.status)
        note_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
      if (m_axis_tlast !== want.last)
        note_mismatch("last", 32'(want.last), 32'(m_axis_tlast));
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    logic        ready_next;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) check_result();
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      m_axis_tready <= ready_next;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    calc_result_t typed_result;
    int unsigned base_live;
    int unsigned random_done;
    int unsigned scenario;
    int unsigned count;
    bit          first_fill;

    // Rows with typed results: errors, extremes and states right after reset.
    add_row(rpnsc_pkg::MODE_POP,   32'h0,     1'b1, 32'h0,    rpnsc_pkg::ST_FEW,  5'd0);
    add_row(rpnsc_pkg::MODE_PEEK,  32'h0,     1'b1, 32'h0,    rpnsc_pkg::ST_FEW,  5'd0);
    add_row(rpnsc_pkg::MODE_DUMP,  32'h0,     1'b1, 32'h0,    rpnsc_pkg::ST_FEW,  5'd0);
    add_row(rpnsc_pkg::MODE_DUP,   32'h0,     1'b1, 32'h0,    rpnsc_pkg::ST_FEW,  5'd0);
    add_row(rpnsc_pkg::MODE_ADD,   32'h0,     1'b1, 32'h0,    rpnsc_pkg::ST_FEW,  5'd0);
    add_row(rpnsc_pkg::MODE_PUSH,  WORD_MIN,  1'b1, 32'h0,    rpnsc_pkg::ST_OK,   5'd1);
    add_row(rpnsc_pkg::MODE_SWAP,  32'h0,     1'b1, 32'h0,    rpnsc_pkg::ST_FEW,  5'd1);
    add_row(rpnsc_pkg::MODE_MUL,   32'h0,     1'b1, 32'h0,    rpnsc_pkg::ST_FEW,  5'd1);
    add_row(rpnsc_pkg::MODE_PUSH,  WORD_NEG1, 1'b1, 32'h0,    rpnsc_pkg::ST_OK,   5'd2);
    add_row(rpnsc_pkg::MODE_DIV,   32'h0,     1'b1, WORD_MIN, rpnsc_pkg::ST_OK,   5'd1);
    add_row(rpnsc_pkg::MODE_PUSH,  32'h0,     1'b1, 32'h0,    rpnsc_pkg::ST_OK,   5'd2);
    add_row(rpnsc_pkg::MODE_DIV,   32'h0,     1'b1, 32'h0,    rpnsc_pkg::ST_DIV0, 5'd2);
    add_row(MODE_UNUSED_LO,        WORD_NEG1, 1'b1, 32'h0,    rpnsc_pkg::ST_OK,   5'd2);
    add_row(MODE_UNUSED_HI,        WORD_MAX,  1'b1, 32'h0,    rpnsc_pkg::ST_OK,   5'd2);
    add_row(rpnsc_pkg::MODE_CLEAR, WORD_NEG1, 1'b1, 32'h0,    rpnsc_pkg::ST_OK,   5'd0);
    add_row(rpnsc_pkg::MODE_CLEAR, 32'h0,     1'b1, 32'h0,    rpnsc_pkg::ST_OK,   5'd0);
    add_row(rpnsc_pkg::MODE_PUSH,  WORD_MAX,  1'b1, 32'h0,    rpnsc_pkg::ST_OK,   5'd1);
    add_row(rpnsc_pkg::MODE_PUSH,  32'h1,     1'b1, 32'h0,    rpnsc_pkg::ST_OK,   5'd2);
    add_row(rpnsc_pkg::MODE_ADD,   32'h0,     1'b1, WORD_MIN, rpnsc_pkg::ST_OK,   5'd1);
    // From here the model supplies the results: operand order and rounding.
    add_row(rpnsc_pkg::MODE_PUSH,  -32'sd7,   1'b0, 32'h0,    rpnsc_pkg::ST_OK,   5'd0);
    add_row(rpnsc_pkg::MODE_PUSH,  32'd2,     1'b0, 32'h0,    rpnsc_pkg::ST_OK,   5'd0);
    add_row(rpnsc_pkg::MODE_SUB,   32'h0,     1'b0, 32'h0,    rpnsc_pkg::ST_OK,   5'd0);
    add_row(rpnsc_pkg::MODE_PUSH,  32'd2,     1'b0, 32'h0,    rpnsc_pkg::ST_OK,   5'd0);
    add_row(rpnsc_pkg::MODE_DIV,   32'h0,     1'b0, 32'h0,    rpnsc_pkg::ST_OK,   5'd0);
    add_row(rpnsc_pkg::MODE_DUP,   32'h0,     1'b0, 32'h0,    rpnsc_pkg::ST_OK,   5'd0);
    add_row(rpnsc_pkg::MODE_MUL,   32'h0,     1'b0, 32'h0,    rpnsc_pkg::ST_OK,   5'd0);
    add_row(rpnsc_pkg::MODE_SWAP,  32'h0,     1'b0, 32'h0,    rpnsc_pkg::ST_OK,   5'd0);
    add_row(rpnsc_pkg::MODE_DUMP,  32'h0,     1'b0, 32'h0,    rpnsc_pkg::ST_OK,   5'd0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_command(row.mode, row.value);
      if (row.typed) begin
        void'(owed_results.pop_back());
        typed_result.data   = row.data;
        typed_result.status = row.status;
        typed_result.fill   = row.fill;
        typed_result.last   = 1'b1;
        owed_results.push_back(typed_result);
      end
    end

    base_live  = live_commands;
    first_fill = 1'b1;
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      if (random_done + CALM_ITEMS >= RANDOM_ITEMS) idle_on = 1'b0;
      scenario = first_fill ? 0 : $urandom_range(0, 9);
      if (scenario == 0) begin
        // Fill to the top, hit it, dump the lot, then unwind.
        if (first_fill) long_hold_req = 1'b1;
        first_fill = 1'b0;
        while (calc_depth < STACK_DEPTH) send_command(rpnsc_pkg::MODE_PUSH, pick_word());
        send_command(rpnsc_pkg::MODE_PUSH, pick_word());
        send_command(rpnsc_pkg::MODE_DUP, pick_word());
        send_command(rpnsc_pkg::MODE_DUMP, pick_word());
        if ($urandom_range(0, 1) == 0) send_command(rpnsc_pkg::MODE_CLEAR, pick_word());
        else repeat ($urandom_range(4, 12)) send_command(rpnsc_pkg::MODE_POP, pick_word());
      end else if (scenario <= 7) begin
        // A short expression: operands, then operators.
        count = $urandom_range(1, 4);
        repeat (count) send_command(rpnsc_pkg::MODE_PUSH, pick_word());
        count = $urandom_range(1, 4);
        repeat (count) begin
          case ($urandom_range(0, 9))
            0: send_command(rpnsc_pkg::MODE_SWAP, pick_word());
            1: send_command(rpnsc_pkg::MODE_DUP, pick_word());
            2: send_command(rpnsc_pkg::MODE_PEEK, pick_word());
            3: send_command(rpnsc_pkg::MODE_POP, pick_word());
            default:
              send_command(rpnsc_pkg::MODE_ADD + 4'($urandom_range(0, 3)), pick_word());
          endcase
        end
        if ($urandom_range(0, 5) == 0) send_command(rpnsc_pkg::MODE_DUMP, pick_word());
      end else begin
        // Noise: any code, any value.
        repeat ($urandom_range(1, 6))
          send_command(4'($urandom_range(0, 15)), $urandom);
      end
      random_done = live_commands - base_live;
    end
    s_axis_tvalid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands (%0d with ignored codes), checked %0d results",
             commands_sent, ignored_commands, results_seen);
    $display("Included %0d dumps, %0d full-stack rejects, %0d mismatches",
             dumps_done, full_rejects, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule : testbench
